FILE: rtl/gdgc_pkg.sv
package gdgc_pkg;

    // Default sizes handed to the top level
    localparam int WEIGHT_BITS_DEF = 18;
    localparam int TIMER_BITS_DEF  = 16;

    // Field widths fixed by the register map and the result word
    localparam int ANGLE_W    = 8;
    localparam int TICKS_W    = 16;
    localparam int GRAMS_W    = 16;
    localparam int CMD_W      = 2;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Commands
    localparam logic [CMD_W-1:0] CMD_EVAL  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd3;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE        = 3'd0;
    localparam logic [PHASE_W-1:0] PH_MAIN        = 3'd1;
    localparam logic [PHASE_W-1:0] PH_MAIN_SETTLE = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SLOW        = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SLOW_SETTLE = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FULL_ANGLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHUT_ANGLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_ANGLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_TICKS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SMALL_REM    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_REM   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_MARGIN  = 3'd7;

    // Reciprocal of three scaled by 2^9, exact for magnitudes up to 255
    localparam logic [ANGLE_W-1:0] RECIP3     = 8'd171;
    localparam int                 RECIP3_SHR = 9;

    typedef struct packed {
        logic [ANGLE_W-1:0] full_angle;
        logic [ANGLE_W-1:0] shut_angle;
        logic [ANGLE_W-1:0] slow_angle;
        logic [TICKS_W-1:0] settle_ticks;
        logic [TICKS_W-1:0] burst_ticks;
        logic [GRAMS_W-1:0] small_remaining;
        logic [GRAMS_W-1:0] medium_remaining;
        logic [GRAMS_W-1:0] stop_margin;
    } cfg_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] servo_angle;
        logic               servo_write;
        logic               feeding;
        logic               dosing_active;
        logic [PHASE_W-1:0] phase;
    } res_t;

    // Partial gate opening: closed - (closed - open) / 2 or / 3, truncated toward zero.
    function automatic logic [ANGLE_W-1:0] part_angle(
        input logic [ANGLE_W-1:0] shut_angle,
        input logic [ANGLE_W-1:0] full_angle,
        input logic               third
    );
        logic [ANGLE_W:0]     range;
        logic                 neg;
        logic [ANGLE_W-1:0]   mag;
        logic [2*ANGLE_W-1:0] prod;
        logic [ANGLE_W-1:0]   quot;
        range = {1'b0, shut_angle} - {1'b0, full_angle};
        neg   = range[ANGLE_W];
        mag   = neg ? ANGLE_W'(-range) : range[ANGLE_W-1:0];
        prod  = mag * RECIP3;
        quot  = third ? ANGLE_W'(prod >> RECIP3_SHR) : (mag >> 1);
        return neg ? (shut_angle + quot) : (shut_angle - quot);
    endfunction

endpackage

FILE: rtl/gdgc_in_if.sv
interface gdgc_in_if #(
    parameter int WEIGHT_BITS = gdgc_pkg::WEIGHT_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [gdgc_pkg::CMD_W-1:0]    command;
    logic [WEIGHT_BITS-2:0]        target_weight;
    logic signed [WEIGHT_BITS-1:0] current_weight;

    modport source (
        output valid, command, target_weight, current_weight,
        input  ready
    );

    modport sink (
        input  valid, command, target_weight, current_weight,
        output ready
    );
endinterface

FILE: rtl/gdgc_out_if.sv
interface gdgc_out_if;
    logic                         valid;
    logic                         ready;
    logic [gdgc_pkg::ANGLE_W-1:0] servo_angle;
    logic                         servo_write;
    logic                         feeding;
    logic                         dosing_active;
    logic [gdgc_pkg::PHASE_W-1:0] phase;

    modport source (
        output valid, servo_angle, servo_write, feeding, dosing_active, phase,
        input  ready
    );

    modport sink (
        input  valid, servo_angle, servo_write, feeding, dosing_active, phase,
        output ready
    );
endinterface

FILE: rtl/gdgc_seq.sv
module gdgc_seq #(
    parameter int WEIGHT_BITS = gdgc_pkg::WEIGHT_BITS_DEF,
    parameter int TIMER_BITS  = gdgc_pkg::TIMER_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [gdgc_pkg::CMD_W-1:0]    cmd,
    input  logic [WEIGHT_BITS-2:0]        target_weight,
    input  logic signed [WEIGHT_BITS-1:0] current_weight,
    input  gdgc_pkg::cfg_t                cfg,
    output gdgc_pkg::res_t                res
);
    import gdgc_pkg::*;

    // Remaining weight needs one bit over the measurement and must hold the 16-bit limits.
    localparam int REM_W = (WEIGHT_BITS + 1 > GRAMS_W + 1) ? WEIGHT_BITS + 1 : GRAMS_W + 1;
    localparam int CMP_W = (TIMER_BITS > TICKS_W) ? TIMER_BITS : TICKS_W;

    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic [ANGLE_W-1:0]    angle_reg, angle_next;
    logic                  feed_reg, feed_next;
    logic [TIMER_BITS-1:0] settle_reg, settle_next;
    logic [TIMER_BITS-1:0] burst_reg, burst_next;

    logic signed [REM_W-1:0] tgt_s;
    logic signed [REM_W-1:0] cur_s;
    logic signed [REM_W-1:0] remaining;
    logic signed [REM_W-1:0] small_s;
    logic signed [REM_W-1:0] medium_s;
    logic signed [REM_W-1:0] margin_s;
    logic                    reached;
    logic                    near_stop;
    logic                    settle_done;
    logic                    burst_done;
    logic [ANGLE_W-1:0]      main_angle;
    logic                    send;
    logic [ANGLE_W-1:0]      send_angle;
    logic                    wrote;

    // Weight comparisons, all done on the signed remainder
    always_comb
    begin
        tgt_s     = REM_W'($signed({1'b0, target_weight}));
        cur_s     = REM_W'(current_weight);
        remaining = tgt_s - cur_s;
        small_s   = REM_W'($signed({1'b0, cfg.small_remaining}));
        medium_s  = REM_W'($signed({1'b0, cfg.medium_remaining}));
        margin_s  = REM_W'($signed({1'b0, cfg.stop_margin}));
        reached   = (remaining <= 0);
        near_stop = (remaining <= margin_s);
    end

    // Timer checks
    assign settle_done = (CMP_W'(settle_reg) >= CMP_W'(cfg.settle_ticks));
    assign burst_done  = (CMP_W'(burst_reg) >= CMP_W'(cfg.burst_ticks));

    // Gate angle during main fill
    always_comb
    begin
        if (remaining < small_s)
        begin
            main_angle = part_angle(cfg.shut_angle, cfg.full_angle, 1'b1);
        end
        else if (remaining < medium_s)
        begin
            main_angle = part_angle(cfg.shut_angle, cfg.full_angle, 1'b0);
        end
        else
        begin
            main_angle = cfg.full_angle;
        end
    end

    // Phase sequencing for one command word
    always_comb
    begin
        phase_next  = phase_reg;
        feed_next   = feed_reg;
        settle_next = settle_reg;
        burst_next  = burst_reg;
        send        = 1'b0;
        send_angle  = cfg.shut_angle;

        case (cmd)
            CMD_EVAL:
            begin
                if (phase_reg != PH_IDLE && reached)
                begin
                    phase_next = PH_IDLE;
                    send       = 1'b1;
                    send_angle = cfg.shut_angle;
                    feed_next  = 1'b0;
                end
                else
                begin
                    case (phase_reg)
                        PH_MAIN:
                        begin
                            send = 1'b1;
                            if (near_stop)
                            begin
                                send_angle  = cfg.shut_angle;
                                feed_next   = 1'b0;
                                phase_next  = PH_MAIN_SETTLE;
                                settle_next = '0;
                            end
                            else
                            begin
                                send_angle = main_angle;
                            end
                        end
                        PH_MAIN_SETTLE, PH_SLOW_SETTLE:
                        begin
                            if (settle_done)
                            begin
                                send       = 1'b1;
                                send_angle = cfg.slow_angle;
                                feed_next  = 1'b1;
                                phase_next = PH_SLOW;
                                burst_next = '0;
                            end
                        end
                        PH_SLOW:
                        begin
                            if (burst_done)
                            begin
                                send        = 1'b1;
                                send_angle  = cfg.shut_angle;
                                feed_next   = 1'b0;
                                phase_next  = PH_SLOW_SETTLE;
                                settle_next = '0;
                            end
                        end
                        default:
                        begin
                            send       = 1'b1;
                            send_angle = cfg.shut_angle;
                            feed_next  = 1'b0;
                        end
                    endcase
                end
            end
            CMD_START:
            begin
                phase_next = PH_MAIN;
                feed_next  = 1'b1;
            end
            CMD_STOP:
            begin
                phase_next = PH_IDLE;
                send       = 1'b1;
                send_angle = cfg.shut_angle;
                feed_next  = 1'b0;
            end
            default:
            begin
                // Millisecond tick: both timers count and saturate.
                if (settle_reg != '1)
                begin
                    settle_next = settle_reg + 1'b1;
                end
                if (burst_reg != '1)
                begin
                    burst_next = burst_reg + 1'b1;
                end
            end
        endcase

        // The servo only gets a word when the angle really changes.
        wrote      = send && (send_angle != angle_reg);
        angle_next = wrote ? send_angle : angle_reg;
    end

    // Result of this word, taken by the output register
    always_comb
    begin
        res.servo_angle   = angle_next;
        res.servo_write   = wrote;
        res.feeding       = feed_next;
        res.dosing_active = (phase_next != PH_IDLE);
        res.phase         = phase_next;
    end

    // Controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            angle_reg  <= '0;
            feed_reg   <= 1'b0;
            settle_reg <= '0;
            burst_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            angle_reg  <= angle_next;
            feed_reg   <= feed_next;
            settle_reg <= settle_next;
            burst_reg  <= burst_next;
        end
    end

endmodule

FILE: rtl/gravimetric_dosing_gate_controller.sv
// A command word is held in the input word register; its result word is worked out from it
// and held in the result word register, which drives the output channel.
// Throughput: one command word per cycle while the result side keeps taking words; a result
// word that waits lets one more command word in and then holds the input.
// Reset clears the phase, feeder, last angle and both timers, and loads the register
// defaults (angles 90, settle and burst 1000 ticks, limits 200, 400 and 50 grams).
module gravimetric_dosing_gate_controller #(
    parameter int WEIGHT_BITS = gdgc_pkg::WEIGHT_BITS_DEF,
    parameter int TIMER_BITS  = gdgc_pkg::TIMER_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    gdgc_in_if.sink                           in_ch,
    gdgc_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [gdgc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gdgc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gdgc_pkg::*;

    cfg_t                          cfg_reg;
    logic                          s1_valid_reg;
    logic [CMD_W-1:0]              s1_cmd_reg;
    logic [WEIGHT_BITS-2:0]        s1_tgt_reg;
    logic signed [WEIGHT_BITS-1:0] s1_cur_reg;
    logic                          out_valid_reg;
    res_t                          out_res_reg;
    res_t                          res;
    logic                          advance;
    logic                          in_take;

    // Move a word to the output whenever the result register is free or being drained.
    assign advance      = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !s1_valid_reg || advance;
    assign in_take      = in_ch.valid && in_ch.ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_angle       <= 8'd90;
            cfg_reg.shut_angle       <= 8'd90;
            cfg_reg.slow_angle       <= 8'd90;
            cfg_reg.settle_ticks     <= 16'd1000;
            cfg_reg.burst_ticks      <= 16'd1000;
            cfg_reg.small_remaining  <= 16'd200;
            cfg_reg.medium_remaining <= 16'd400;
            cfg_reg.stop_margin      <= 16'd50;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FULL_ANGLE:   cfg_reg.full_angle       <= cfg_data[ANGLE_W-1:0];
                REG_SHUT_ANGLE:   cfg_reg.shut_angle       <= cfg_data[ANGLE_W-1:0];
                REG_SLOW_ANGLE:   cfg_reg.slow_angle       <= cfg_data[ANGLE_W-1:0];
                REG_SETTLE_TICKS: cfg_reg.settle_ticks     <= cfg_data[TICKS_W-1:0];
                REG_BURST_TICKS:  cfg_reg.burst_ticks      <= cfg_data[TICKS_W-1:0];
                REG_SMALL_REM:    cfg_reg.small_remaining  <= cfg_data[GRAMS_W-1:0];
                REG_MEDIUM_REM:   cfg_reg.medium_remaining <= cfg_data[GRAMS_W-1:0];
                REG_STOP_MARGIN:  cfg_reg.stop_margin      <= cfg_data[GRAMS_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input stage valid and output stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input word register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg <= in_ch.command;
            s1_tgt_reg <= in_ch.target_weight;
            s1_cur_reg <= in_ch.current_weight;
        end
    end

    // Result word register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    gdgc_seq #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .TIMER_BITS  (TIMER_BITS)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .cmd            (s1_cmd_reg),
        .target_weight  (s1_tgt_reg),
        .current_weight (s1_cur_reg),
        .cfg            (cfg_reg),
        .res            (res)
    );

    // Output channel
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.servo_angle   = out_res_reg.servo_angle;
    assign out_ch.servo_write   = out_res_reg.servo_write;
    assign out_ch.feeding       = out_res_reg.feeding;
    assign out_ch.dosing_active = out_res_reg.dosing_active;
    assign out_ch.phase         = out_res_reg.phase;

endmodule

FILE: test/gdgc_dose_checker.sv
`timescale 1ns / 1ps

// Watches the command and result channels of the dosing gate controller, keeps its own
// copy of the controller state and registers, and compares every result word with the
// oldest prediction.
module gdgc_dose_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    gdgc_in_if                              cmd_mon,
    gdgc_out_if                             res_mon,
    input  logic                            cfg_we,
    input  logic [gdgc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gdgc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              outstanding
);
    import gdgc_pkg::*;

    localparam int TMR_W = TIMER_BITS_DEF;

    // Shadow registers and controller state.
    cfg_t               regs;
    logic [PHASE_W-1:0] phase_q;
    logic [ANGLE_W-1:0] angle_q;
    logic               feed_q;
    logic [TMR_W-1:0]   settle_cnt;
    logic [TMR_W-1:0]   burst_cnt;
    logic               wrote;

    res_t expected_q[$];
    int   errs = 0;

    // A new angle only goes to the servo when it differs from the last one sent.
    function automatic void move_gate(input logic [ANGLE_W-1:0] a);
        if (a != angle_q) begin
            angle_q = a;
            wrote   = 1'b1;
        end
    endfunction

    // Entering a settle phase restarts the settle timer, entering slow fill the burst timer.
    function automatic void switch_phase(input logic [PHASE_W-1:0] p);
        phase_q = p;
        if (p == PH_MAIN_SETTLE || p == PH_SLOW_SETTLE)
            settle_cnt = '0;
        else if (p == PH_SLOW)
            burst_cnt = '0;
    endfunction

    function automatic void halt_dose();
        switch_phase(PH_IDLE);
        move_gate(regs.shut_angle);
        feed_q = 1'b0;
    endfunction

    // Main fill opening: full, half or a third of the range, division truncating to zero.
    function automatic logic [ANGLE_W-1:0] fill_angle(input longint missing);
        int span;
        span = int'(regs.shut_angle) - int'(regs.full_angle);
        if (missing < longint'(regs.small_remaining))
            return ANGLE_W'(int'(regs.shut_angle) - span / 3);
        if (missing < longint'(regs.medium_remaining))
            return ANGLE_W'(int'(regs.shut_angle) - span / 2);
        return regs.full_angle;
    endfunction

    function automatic void weigh(input longint tgt, input longint cur);
        // Reaching the target in any active phase ends the dose.
        if (phase_q != PH_IDLE && cur >= tgt) begin
            halt_dose();
            return;
        end
        case (phase_q)
            PH_MAIN:
            begin
                if (cur >= tgt - longint'(regs.stop_margin)) begin
                    move_gate(regs.shut_angle);
                    feed_q = 1'b0;
                    switch_phase(PH_MAIN_SETTLE);
                end
                else begin
                    move_gate(fill_angle(tgt - cur));
                end
            end
            PH_MAIN_SETTLE, PH_SLOW_SETTLE:
            begin
                if (settle_cnt >= regs.settle_ticks) begin
                    move_gate(regs.slow_angle);
                    feed_q = 1'b1;
                    switch_phase(PH_SLOW);
                end
            end
            PH_SLOW:
            begin
                if (burst_cnt >= regs.burst_ticks) begin
                    move_gate(regs.shut_angle);
                    feed_q = 1'b0;
                    switch_phase(PH_SLOW_SETTLE);
                end
            end
            default:
            begin
                move_gate(regs.shut_angle);
                feed_q = 1'b0;
            end
        endcase
    endfunction

    // Works out the result word for one command word.
    task automatic dose_step(
        input  logic [CMD_W-1:0]                  cmd,
        input  logic [WEIGHT_BITS_DEF-2:0]        tgt_w,
        input  logic signed [WEIGHT_BITS_DEF-1:0] cur_w,
        output res_t                              r
    );
        longint tgt;
        longint cur;
        tgt   = longint'(tgt_w);
        cur   = longint'(cur_w);
        wrote = 1'b0;
        case (cmd)
            CMD_EVAL:
                weigh(tgt, cur);
            CMD_START:
            begin
                switch_phase(PH_MAIN);
                feed_q = 1'b1;
            end
            CMD_STOP:
                halt_dose();
            default:
            begin
                // Both timers count every tick and stick at full scale.
                if (settle_cnt != '1)
                    settle_cnt = settle_cnt + 1'b1;
                if (burst_cnt != '1)
                    burst_cnt = burst_cnt + 1'b1;
            end
        endcase
        r.servo_angle   = angle_q;
        r.servo_write   = wrote;
        r.feeding       = feed_q;
        r.dosing_active = (phase_q != PH_IDLE);
        r.phase         = phase_q;
    endtask

    task automatic write_shadow(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_FULL_ANGLE:   regs.full_angle       = d[ANGLE_W-1:0];
            REG_SHUT_ANGLE:   regs.shut_angle       = d[ANGLE_W-1:0];
            REG_SLOW_ANGLE:   regs.slow_angle       = d[ANGLE_W-1:0];
            REG_SETTLE_TICKS: regs.settle_ticks     = d[TICKS_W-1:0];
            REG_BURST_TICKS:  regs.burst_ticks      = d[TICKS_W-1:0];
            REG_SMALL_REM:    regs.small_remaining  = d[GRAMS_W-1:0];
            REG_MEDIUM_REM:   regs.medium_remaining = d[GRAMS_W-1:0];
            REG_STOP_MARGIN:  regs.stop_margin      = d[GRAMS_W-1:0];
            default: ;
        endcase
    endtask

    // Compares one accepted result word against the oldest prediction.
    task automatic check_result();
        res_t want;
        res_t got;
        got.servo_angle   = res_mon.servo_angle;
        got.servo_write   = res_mon.servo_write;
        got.feeding       = res_mon.feeding;
        got.dosing_active = res_mon.dosing_active;
        got.phase         = res_mon.phase;
        if (expected_q.size() == 0) begin
            errs++;
            if (errs <= 10)
                $display("%0t: result word with none expected: angle %0d write %0b feed %0b",
                         $realtime, got.servo_angle, got.servo_write, got.feeding);
            return;
        end
        want = expected_q.pop_front();
        if (got.servo_angle !== want.servo_angle || got.servo_write !== want.servo_write ||
            got.feeding !== want.feeding || got.dosing_active !== want.dosing_active ||
            got.phase !== want.phase) begin
            errs++;
            if (errs <= 10) begin
                $write("%0t: result mismatch: expected angle %0d write %0b feed %0b",
                       $realtime, want.servo_angle, want.servo_write, want.feeding);
                $write(" active %0b phase %0d,", want.dosing_active, want.phase);
                $display(" got angle %0d write %0b feed %0b active %0b phase %0d",
                         got.servo_angle, got.servo_write, got.feeding,
                         got.dosing_active, got.phase);
            end
        end
    endtask

    // Results are checked before the new command word is predicted, since a result word
    // never belongs to a command word accepted at the same edge.
    always @(posedge clk or negedge rst_n) begin
        res_t r;
        if (!rst_n) begin
            regs.full_angle       = 8'd90;
            regs.shut_angle       = 8'd90;
            regs.slow_angle       = 8'd90;
            regs.settle_ticks     = 16'd1000;
            regs.burst_ticks      = 16'd1000;
            regs.small_remaining  = 16'd200;
            regs.medium_remaining = 16'd400;
            regs.stop_margin      = 16'd50;
            phase_q               = PH_IDLE;
            angle_q               = '0;
            feed_q                = 1'b0;
            settle_cnt            = '0;
            burst_cnt             = '0;
            expected_q.delete();
            mismatches  <= errs;
            outstanding <= 0;
        end
        else begin
            if (res_mon.valid && res_mon.ready)
                check_result();
            if (cmd_mon.valid && cmd_mon.ready) begin
                dose_step(cmd_mon.command, cmd_mon.target_weight, cmd_mon.current_weight, r);
                expected_q.push_back(r);
            end
            if (cfg_we)
                write_shadow(cfg_index, cfg_data);
            mismatches  <= errs;
            outstanding <= expected_q.size();
        end
    end

endmodule

FILE: test/tb_gravimetric_dosing_gate_controller.sv
`timescale 1ns / 1ps

module tb_gravimetric_dosing_gate_controller;
    import gdgc_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TGT_MAX     = 131071;
    localparam int CUR_MIN     = -131072;
    localparam int CUR_MAX     = 131071;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  quiet;
    int                    hold_left = 0;
    int                    cycles = 0;
    int                    words_sent = 0;
    int                    span_top = 700;
    int                    mismatches;
    int                    outstanding;

    gdgc_in_if  cmd_ch();
    gdgc_out_if res_ch();

    gravimetric_dosing_gate_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (cmd_ch),
        .out_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gdgc_dose_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_mon     (cmd_ch),
        .res_mon     (res_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #2 clk = ~clk;

    // Run guard.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("gravimetric_dosing_gate_controller test failed");
            $finish;
        end
    end

    // Result side back-pressure in random bursts, switched off for the last part.
    always @(posedge clk) begin
        if (quiet) begin
            hold_left = 0;
            res_ch.ready <= 1'b1;
        end
        else if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(1, 16) - 1;
            res_ch.ready <= 1'b0;
        end
        else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Sends one command word, now and then after a random gap.
    task automatic push_cmd(input logic [CMD_W-1:0] cmd, input int tgt, input int cur);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.command        <= cmd;
        cmd_ch.target_weight  <= (WEIGHT_BITS_DEF-1)'(tgt);
        cmd_ch.current_weight <= WEIGHT_BITS_DEF'(cur);
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic push_noise();
        push_cmd(CMD_W'($urandom_range(0, 3)), int'($urandom_range(0, TGT_MAX)),
                 int'($urandom_range(0, 262143)) + CUR_MIN);
    endtask

    // Holds the sender back until every predicted result word has come out.
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    // Loads all eight registers; angles get random upper bits that must be dropped.
    task automatic set_regs(input int full_a, input int shut_a, input int slow_a,
                            input int settle, input int burst, input int small_rem,
                            input int medium_rem, input int margin);
        write_reg(REG_FULL_ANGLE,   full_a   + 256 * int'($urandom_range(0, 255)));
        write_reg(REG_SHUT_ANGLE,   shut_a   + 256 * int'($urandom_range(0, 255)));
        write_reg(REG_SLOW_ANGLE,   slow_a   + 256 * int'($urandom_range(0, 255)));
        write_reg(REG_SETTLE_TICKS, settle);
        write_reg(REG_BURST_TICKS,  burst);
        write_reg(REG_SMALL_REM,    small_rem);
        write_reg(REG_MEDIUM_REM,   medium_rem);
        write_reg(REG_STOP_MARGIN,  margin);
        cfg_we <= 1'b0;
        span_top = small_rem;
        if (medium_rem > span_top)
            span_top = medium_rem;
        if (margin > span_top)
            span_top = margin;
        span_top = span_top + 300;
    endtask

    // One dose: start, then weighings that creep toward the target with ticks between,
    // sprinkled with stray words, and a finish by reaching the target, a stop or nothing.
    task automatic fill_cycle(input int steps);
        int tgt;
        int cur;
        int left;
        int pick;
        if ($urandom_range(0, 3) == 0)
            tgt = $urandom_range(0, TGT_MAX);
        else
            tgt = $urandom_range(0, span_top + 3000);
        if (tgt > TGT_MAX)
            tgt = TGT_MAX;
        cur = tgt - int'($urandom_range(0, span_top + 200));
        if (cur < CUR_MIN)
            cur = CUR_MIN;
        push_cmd(CMD_START, tgt, cur);
        repeat (steps) begin
            pick = $urandom_range(0, 19);
            if (pick < 7) begin
                repeat ($urandom_range(1, 3)) push_cmd(CMD_TICK, tgt, cur);
            end
            else if (pick < 18) begin
                left = tgt - cur;
                if ($urandom_range(0, 9) == 0)
                    cur = cur + left + int'($urandom_range(0, 5));
                else if (left > 0)
                    cur = cur + int'($urandom_range(0, left / 4 + 2));
                if (cur > CUR_MAX)
                    cur = CUR_MAX;
                push_cmd(CMD_EVAL, tgt, cur);
            end
            else begin
                push_noise();
            end
        end
        case ($urandom_range(0, 2))
            0:
            begin
                cur = tgt + int'($urandom_range(0, 3));
                if (cur > CUR_MAX)
                    cur = CUR_MAX;
                push_cmd(CMD_EVAL, tgt, cur);
            end
            1: push_cmd(CMD_STOP, tgt, cur);
            default: ;
        endcase
    endtask

    task automatic random_mix(input int goal);
        int stop_at;
        stop_at = words_sent + goal;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0)
                push_noise();
            else
                fill_cycle($urandom_range(6, 40));
            if ($urandom_range(0, 24) == 0)
                drain();
        end
    endtask

    task automatic pick_settings(input int kind);
        case (kind)
            1: set_regs(10, 170, 10, 1, 1, 0, 0, 0);
            2: set_regs(170, 10, 170, 0, 0, 65535, 65535, 65535);
            3: set_regs(255, 0, 255, 0, 1, 65535, 0, 0);
            4: set_regs(0, 255, 0, 1, 0, 0, 65535, 0);
            default:
                set_regs($urandom_range(10, 170), $urandom_range(10, 170),
                         $urandom_range(10, 170), $urandom_range(1, 6), $urandom_range(1, 6),
                         $urandom_range(0, 600), $urandom_range(0, 800), $urandom_range(0, 100));
        endcase
    endtask

    initial begin
        int kinds[7];
        kinds = '{0, 1, 0, 2, 3, 0, 4};

        rst_n                 = 1'b0;
        quiet                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = REG_FULL_ANGLE;
        cfg_data              = '0;
        cmd_ch.valid          = 1'b0;
        cmd_ch.command        = CMD_EVAL;
        cmd_ch.target_weight  = '0;
        cmd_ch.current_weight = '0;
        res_ch.ready          = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values, then a zero closed angle before anything was written: no servo write.
        push_cmd(CMD_TICK, 0, 0);
        push_cmd(CMD_START, 0, 0);
        push_cmd(CMD_TICK, 0, 0);
        drain();
        set_regs(0, 0, 0, 1000, 1000, 200, 400, 50);
        push_cmd(CMD_STOP, 0, 0);
        push_cmd(CMD_EVAL, 0, 0);
        drain();

        // Walk one dose through every phase with short timers.
        set_regs(30, 150, 100, 2, 2, 200, 400, 50);
        push_cmd(CMD_EVAL, 0, 0);
        push_cmd(CMD_START, 0, 0);
        push_cmd(CMD_EVAL, TGT_MAX, CUR_MIN);
        push_cmd(CMD_EVAL, 1000, 650);
        push_cmd(CMD_EVAL, 1000, 850);
        push_cmd(CMD_EVAL, 1000, 950);
        push_cmd(CMD_EVAL, 1000, 950);
        push_cmd(CMD_TICK, 0, 0);
        push_cmd(CMD_TICK, 0, 0);
        push_cmd(CMD_EVAL, 1000, 960);
        push_cmd(CMD_TICK, 0, 0);
        push_cmd(CMD_EVAL, 1000, 970);
        push_cmd(CMD_TICK, 0, 0);
        push_cmd(CMD_EVAL, 1000, 980);
        push_cmd(CMD_TICK, 0, 0);
        push_cmd(CMD_TICK, 0, 0);
        push_cmd(CMD_EVAL, 1000, 990);
        push_cmd(CMD_EVAL, 1000, 1000);
        push_cmd(CMD_START, 0, 0);
        push_cmd(CMD_STOP, 0, 0);
        push_cmd(CMD_START, 0, 0);
        push_cmd(CMD_EVAL, 0, CUR_MAX);
        drain();

        // Random doses under a series of register settings.
        foreach (kinds[k]) begin
            pick_settings(kinds[k]);
            random_mix(150);
            drain();
        end

        // Last part without idling: longer timers counted out back to back.
        quiet <= 1'b1;
        set_regs(40, 120, 60, 20, 20, 200, 400, 50);
        push_cmd(CMD_START, 0, 0);
        push_cmd(CMD_EVAL, 1000, 960);
        push_cmd(CMD_EVAL, 1000, 960);
        repeat (24) push_cmd(CMD_TICK, 0, 0);
        push_cmd(CMD_EVAL, 1000, 960);
        push_cmd(CMD_EVAL, 1000, 965);
        repeat (24) push_cmd(CMD_TICK, 0, 0);
        push_cmd(CMD_EVAL, 1000, 970);
        push_cmd(CMD_TICK, 0, 0);
        push_cmd(CMD_EVAL, 1000, 975);
        push_cmd(CMD_EVAL, 1000, 1000);
        drain();
        pick_settings(0);
        random_mix(100);

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("gravimetric_dosing_gate_controller test passed");
        else
            $display("gravimetric_dosing_gate_controller test failed");
        $finish;
    end

endmodule
